>>> hdl/siq_pkg.sv
// Package for the sorted insertion queue: sizes, action codes, item structs and sequencer states.
// No dependencies.
`default_nettype none

package siq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } t_action;

    typedef struct packed {
        logic                         action;
        logic signed [DATA_WIDTH-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] top_value;
        logic [CNT_W-1:0]             count;
        logic                         empty_res;
        logic                         error;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH_CMP,
        ST_PUSH_PLACE,
        ST_POP_MOVE,
        ST_TOP_RD,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

>>> hdl/sorted_insertion_queue.sv
// Sorted insertion queue top level: entry memory plus a small sequencer around one comparator.
// Depends on siq_pkg.
`default_nettype none

// Usage
// -----
// Command port: drive i_item and raise start; the item is taken at the edge where start
// is high and busy is low. busy then stays high until the result has been shown.
// Result port: o_item is valid for exactly one cycle, marked by o_done. The receiver
// cannot stall it; it must take the item in that cycle.
// Entries live in a 16-entry memory with one write port and one registered read port,
// kept ascending from address 0 (the top). All work goes through that single port pair
// and one signed comparator:
//   push  - walk up from the bottom entry, moving each larger-or-equal entry down by one
//           (one entry per cycle: the next read overlaps the compare and write),
//           then drop the new value into the gap; a push into an empty queue writes
//           the value straight to address 0.
//   pop   - move entries 1..count-1 up by one, one per cycle.
//   error - push when full or pop when empty: no change to the entries or the count.
// Every item finishes with a read of address 0 to report the new top value.
// One item is in flight at a time; the next start is taken the cycle after o_done.
//
// Reset (synchronous, active low) clears the entry count and the sequencer; memory
// contents are not cleared, since only entries below the count are ever used.
module sorted_insertion_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  siq_pkg::t_in_item   i_item,
    output logic                o_done,
    output siq_pkg::t_out_item  o_item
);

    localparam int AW = siq_pkg::ADDR_W;
    localparam int CW = siq_pkg::CNT_W;
    localparam int DW = siq_pkg::DATA_WIDTH;

    // entry storage
    logic signed [DW-1:0] r_mem [siq_pkg::DEPTH];
    logic signed [DW-1:0] r_rdata;

    // sequencer
    siq_pkg::t_state      r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_idx,   n_idx;
    logic signed [DW-1:0] r_value, n_value;
    logic                 r_err,   n_err;

    // memory port controls
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [DW-1:0] wr_data;

    logic [CW-1:0]        idx_m1, idx_m2, idx_p1, cnt_m1;
    logic                 accept;
    logic                 move_down;

    assign accept    = start && !busy;
    assign idx_m1    = r_idx - CW'(1);
    assign idx_m2    = r_idx - CW'(2);
    assign idx_p1    = r_idx + CW'(1);
    assign cnt_m1    = r_count - CW'(1);
    // single comparator: stored entry goes below the new value when not smaller
    assign move_down = (r_rdata >= r_value);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= siq_pkg::ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_value = r_value;
        n_err   = r_err;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_value;
        busy    = 1'b1;
        o_done  = 1'b0;

        case (r_state)
            siq_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (accept) begin
                    n_value = i_item.value;
                    n_err   = 1'b0;
                    if (i_item.action == siq_pkg::ACT_PUSH) begin
                        if (r_count == CW'(siq_pkg::DEPTH)) begin
                            n_err   = 1'b1;
                            n_state = siq_pkg::ST_TOP_RD;
                        end else if (r_count == '0) begin
                            wr_en   = 1'b1;
                            wr_addr = '0;
                            wr_data = i_item.value;
                            n_count = CW'(1);
                            n_state = siq_pkg::ST_TOP_RD;
                        end else begin
                            // start at the bottom entry
                            n_idx   = r_count;
                            rd_addr = cnt_m1[AW-1:0];
                            n_state = siq_pkg::ST_PUSH_CMP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_err   = 1'b1;
                            n_state = siq_pkg::ST_TOP_RD;
                        end else if (r_count == CW'(1)) begin
                            n_count = '0;
                            n_state = siq_pkg::ST_TOP_RD;
                        end else begin
                            n_idx   = CW'(1);
                            rd_addr = AW'(1);
                            n_state = siq_pkg::ST_POP_MOVE;
                        end
                    end
                end
            end

            siq_pkg::ST_PUSH_CMP: begin
                // r_rdata holds entry idx-1
                wr_en   = 1'b1;
                wr_addr = r_idx[AW-1:0];
                if (move_down) begin
                    wr_data = r_rdata;
                    n_idx   = idx_m1;
                    if (idx_m1 == '0) begin
                        n_state = siq_pkg::ST_PUSH_PLACE;
                    end else begin
                        rd_addr = idx_m2[AW-1:0];
                        n_state = siq_pkg::ST_PUSH_CMP;
                    end
                end else begin
                    wr_data = r_value;
                    n_count = r_count + CW'(1);
                    n_state = siq_pkg::ST_TOP_RD;
                end
            end

            siq_pkg::ST_PUSH_PLACE: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = r_value;
                n_count = r_count + CW'(1);
                n_state = siq_pkg::ST_TOP_RD;
            end

            siq_pkg::ST_POP_MOVE: begin
                // r_rdata holds entry idx; move it up one place
                wr_en   = 1'b1;
                wr_addr = idx_m1[AW-1:0];
                wr_data = r_rdata;
                if (idx_p1 < r_count) begin
                    n_idx   = idx_p1;
                    rd_addr = idx_p1[AW-1:0];
                end else begin
                    n_count = cnt_m1;
                    n_state = siq_pkg::ST_TOP_RD;
                end
            end

            siq_pkg::ST_TOP_RD: begin
                rd_addr = '0;
                n_state = siq_pkg::ST_DONE;
            end

            siq_pkg::ST_DONE: begin
                o_done  = 1'b1;
                n_state = siq_pkg::ST_IDLE;
            end

            default: begin
                n_state = siq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_item.top_value = (r_count != '0) ? r_rdata : '0;
        o_item.count     = r_count;
        o_item.empty_res = (r_count == '0);
        o_item.error     = r_err;
    end

    // assertions
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(siq_pkg::DEPTH))
        else $error("entry count beyond depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(!i_rst_n) |-> (r_count == $past(r_count)
            || r_count == $past(r_count) + CW'(1)
            || r_count == $past(r_count) - CW'(1)))
        else $error("entry count changed by more than one");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("sequencer not idle after result");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy && !o_done)
        else $error("item taken without going busy");

    a_err_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_item.error) |-> $stable(r_count))
        else $error("refused item changed the count");

endmodule

`default_nettype wire
